// File: hdl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, reset included.
`define ASSERT_AT(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");

// Check a property on every rising clock edge outside reset.
`define ASSERT_AT_RST(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");

`endif

// File: hdl/dpba_pkg.sv
package dpba_pkg;

  localparam int DATA_WIDTH    = 16;
  localparam int ACC_WIDTH_DEF = 48;
  localparam int PROD_WIDTH    = 2 * DATA_WIDTH;
  localparam int RES_WIDTH     = 32;
  localparam int SLOPE_WIDTH   = 16;
  localparam int SLOPE_FRAC    = 12;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 32;

  localparam logic signed [RES_WIDTH-1:0] RES_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [RES_WIDTH-1:0] RES_MIN = 32'sh8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BIAS_ENABLE = 3'd0,
    REG_ACT_MODE    = 3'd1,
    REG_LEAKY_SLOPE = 3'd2,
    REG_CLIP_MIN    = 3'd3,
    REG_CLIP_MAX    = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_RELU  = 2'd1,
    ACT_LEAKY = 2'd2,
    ACT_CLIP  = 2'd3
  } act_mode_t;

  typedef enum logic [1:0] {
    BK_ACC,
    BK_CLAMP,
    BK_LEAK,
    BK_ACT
  } back_state_t;

  typedef struct packed {
    logic                          first_element;
    logic                          last_element;
    logic signed [DATA_WIDTH-1:0]  act_value;
    logic signed [DATA_WIDTH-1:0]  weight_value;
    logic signed [RES_WIDTH-1:0]   bias_value;
  } item_t;

  typedef struct packed {
    logic signed [RES_WIDTH-1:0] result_value;
    logic                        saturated;
  } result_t;

  // Settings the back end needs while it works.
  typedef struct packed {
    act_mode_t                    act_mode;
    logic signed [SLOPE_WIDTH-1:0] leaky_slope;
    logic signed [RES_WIDTH-1:0]  clip_min;
    logic signed [RES_WIDTH-1:0]  clip_max;
  } cfg_t;

  // One word in flight between front and back.
  typedef struct packed {
    logic                          first;
    logic                          last;
    logic signed [PROD_WIDTH-1:0]  prod;
    logic signed [RES_WIDTH-1:0]   base;
  } qword_t;

endpackage

// File: hdl/dot_product_bias_activation.sv
// Fully connected layer multiply-accumulate with bias and activation. Push one
// activation/weight word per cycle while full is low; the word marked first
// starts a new sum from the bias (or zero when bias is disabled), and the word
// marked last closes it, clamps it to 32 bits, applies the configured
// activation (none, ReLU, leaky ReLU, clip) and registers one result word with
// a saturation flag. Words that are not last produce no result. Flow: the front
// multiplies and takes one word per cycle while full is low; the back
// accumulator retires one word per cycle while the queue is not empty, and a
// last word then takes the back through clamp, leaky multiply and activation,
// where it waits for the previous result to be popped. A four-word queue
// between front and back absorbs those extra steps. Write configuration only
// while no run is in flight.
module dot_product_bias_activation
  import dpba_pkg::*;
#(
  parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // input word queue
  input  logic                  push,
  output logic                  full,
  input  item_t                 item,
  // result queue
  output logic                  empty,
  input  logic                  pop,
  output result_t               result,
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic   bias_enable;
  cfg_t   cfg;
  logic   q_push;
  logic   q_full;
  logic   q_pop;
  logic   q_empty;
  qword_t q_in;
  qword_t q_out;

  // Config writes always complete at once; ignore indexes past the list.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bias_enable <= 1'b0;
      cfg         <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BIAS_ENABLE: bias_enable     <= cfg_data[0];
        REG_ACT_MODE:    cfg.act_mode    <= act_mode_t'(cfg_data[1:0]);
        REG_LEAKY_SLOPE: cfg.leaky_slope <= cfg_data[SLOPE_WIDTH-1:0];
        REG_CLIP_MIN:    cfg.clip_min    <= cfg_data[RES_WIDTH-1:0];
        REG_CLIP_MAX:    cfg.clip_max    <= cfg_data[RES_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Front: take a word, form the product and the starting value.
  dpba_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .item        (item),
    .full        (full),
    .bias_enable (bias_enable),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_word      (q_in)
  );

  // Decouple front and back so each can stall on its own.
  dpba_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .word_in  (q_in),
    .full     (q_full),
    .pop      (q_pop),
    .word_out (q_out),
    .empty    (q_empty)
  );

  // Back: accumulate, then finish the run and hold the result word.
  dpba_back #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_word  (q_out),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

endmodule

// File: hdl/dpba_queue.sv
module dpba_queue
  import dpba_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  qword_t word_in,
  output logic   full,
  input  logic   pop,
  output qword_t word_out,
  output logic   empty
);

  qword_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wptr;
  logic [QPTR_W-1:0]  rptr;
  logic [QPTR_W:0]    count;
  logic               do_push;
  logic               do_pop;

  assign full     = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign word_out = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= wptr + 1'b1;
      if (do_pop)  rptr <= rptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wptr] <= word_in;
  end

endmodule

// File: hdl/dpba_front.sv
module dpba_front
  import dpba_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  item_t  item,
  output logic   full,
  input  logic   bias_enable,
  input  logic   q_full,
  output logic   q_push,
  output qword_t q_word
);

  logic   stage_valid;
  qword_t stage;
  qword_t stage_next;
  logic   accept;

  // Hold the stage while the queue is full.
  assign full   = stage_valid && q_full;
  assign accept = push && !full;
  assign q_push = stage_valid;
  assign q_word = stage;

  always_comb begin
    stage_next.first = item.first_element;
    stage_next.last  = item.last_element;
    stage_next.prod  = PROD_WIDTH'($signed(item.act_value)) *
                       PROD_WIDTH'($signed(item.weight_value));
    stage_next.base  = (item.first_element && bias_enable) ? item.bias_value : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (!q_full) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) stage <= stage_next;
  end

endmodule

// File: hdl/dpba_back.sv
module dpba_back
  import dpba_pkg::*;
#(
  parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    q_empty,
  input  qword_t  q_word,
  output logic    q_pop,
  input  logic    pop,
  output logic    empty,
  output result_t result
);

  localparam int SUM_W  = ((ACC_WIDTH > PROD_WIDTH) ? ACC_WIDTH : PROD_WIDTH) + 1;
  localparam int LEAK_W = RES_WIDTH + SLOPE_WIDTH;
  localparam logic [SUM_W-1:0] ACC_HI = (SUM_W'(1) << (ACC_WIDTH - 1)) - SUM_W'(1);
  localparam logic [SUM_W-1:0] ACC_LO = ~ACC_HI;

  back_state_t                 state;
  back_state_t                 state_next;
  logic signed [ACC_WIDTH-1:0] acc;
  logic signed [RES_WIDTH-1:0] xval;
  logic                        sat_q;
  logic signed [LEAK_W-1:0]    leak_prod;
  logic                        out_valid;
  result_t                     out_word;

  logic                        out_load;
  logic signed [ACC_WIDTH-1:0] acc_start;
  logic signed [SUM_W-1:0]     sum;
  logic signed [ACC_WIDTH-1:0] acc_sat;
  logic signed [RES_WIDTH-1:0] x_clamp;
  logic                        x_over;
  logic signed [LEAK_W-1:0]    leak_sh;
  result_t                     res_next;

  always_comb begin
    state_next = state;
    unique case (state)
      BK_ACC:   if (!q_empty && q_word.last) state_next = BK_CLAMP;
      BK_CLAMP: state_next = BK_LEAK;
      BK_LEAK:  state_next = BK_ACT;
      BK_ACT:   if (!out_valid || pop) state_next = BK_ACC;
      default:  state_next = BK_ACC;
    endcase
  end

  always_comb begin
    q_pop    = (state == BK_ACC) && !q_empty;
    out_load = (state == BK_ACT) && (!out_valid || pop);
  end

  // Saturating accumulate of one product.
  always_comb begin
    acc_start = q_word.first ? ACC_WIDTH'($signed(q_word.base)) : acc;
    sum       = SUM_W'(acc_start) + SUM_W'($signed(q_word.prod));
    if (sum > $signed(ACC_HI))      acc_sat = ACC_WIDTH'(ACC_HI);
    else if (sum < $signed(ACC_LO)) acc_sat = ACC_WIDTH'(ACC_LO);
    else                            acc_sat = ACC_WIDTH'(sum);
  end

  // Clamp the finished sum to the result range.
  always_comb begin
    x_over = 1'b1;
    if (acc > ACC_WIDTH'(RES_MAX))      x_clamp = RES_MAX;
    else if (acc < ACC_WIDTH'(RES_MIN)) x_clamp = RES_MIN;
    else begin
      x_clamp = RES_WIDTH'(acc);
      x_over  = 1'b0;
    end
  end

  always_comb begin
    leak_sh  = leak_prod >>> SLOPE_FRAC;
    res_next.result_value = xval;
    res_next.saturated    = sat_q;
    unique case (cfg.act_mode)
      ACT_NONE: ;
      ACT_RELU: if (xval < 0) res_next.result_value = '0;
      ACT_LEAKY: begin
        if (xval <= 0) begin
          if (leak_sh > LEAK_W'(RES_MAX)) begin
            res_next.result_value = RES_MAX;
            res_next.saturated    = 1'b1;
          end else if (leak_sh < LEAK_W'(RES_MIN)) begin
            res_next.result_value = RES_MIN;
            res_next.saturated    = 1'b1;
          end else begin
            res_next.result_value = RES_WIDTH'(leak_sh);
          end
        end
      end
      ACT_CLIP: begin
        if (xval < cfg.clip_min) res_next.result_value = cfg.clip_min;
        if (res_next.result_value > cfg.clip_max) res_next.result_value = cfg.clip_max;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_ACC;
      acc       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (q_pop) acc <= acc_sat;
      else if (state == BK_CLAMP) acc <= '0;
      if (out_load) out_valid <= 1'b1;
      else if (pop) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == BK_CLAMP) begin
      xval  <= x_clamp;
      sat_q <= x_over;
    end
    if (state == BK_LEAK) leak_prod <= LEAK_W'(xval) * LEAK_W'(cfg.leaky_slope);
    if (out_load) out_word <= res_next;
  end

  assign empty  = !out_valid;
  assign result = out_word;

endmodule

// File: hdl/dpba_checker.sv
`include "assert_macros.svh"

module dpba_checker
  import dpba_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    push,
  input logic    full,
  input logic    empty,
  input logic    pop,
  input result_t result,
  input logic    cfg_ready
);

  `ASSERT_AT(a_reset_clears, clk, rst |=> empty && !full)
  `ASSERT_AT_RST(a_result_held, clk, rst, !empty && !pop |=> !empty && $stable(result))
  `ASSERT_AT_RST(a_cfg_ready, clk, rst, cfg_ready)
  `ASSERT_AT_RST(a_full_after_push, clk, rst, $rose(full) |-> $past(push))

endmodule

bind dot_product_bias_activation dpba_checker u_dpba_checker (
  .clk       (clk),
  .rst       (rst),
  .push      (push),
  .full      (full),
  .empty     (empty),
  .pop       (pop),
  .result    (result),
  .cfg_ready (cfg_ready)
);

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import dpba_pkg::*;

  localparam int    ACC_W       = 48;
  localparam longint ACC_TOP    = (longint'(1) <<< (ACC_W - 1)) - 1;
  localparam longint ACC_BOTTOM = -ACC_TOP - 1;
  localparam longint RES_HI     = 64'sd2147483647;
  localparam longint RES_LO     = -64'sd2147483648;
  localparam int    IDLE_PCT    = 19;
  localparam int    SETTLE_CYC  = 12;
  localparam longint CYCLE_LIMIT = 3_000_000;

  // Expected-result store plus a bit-true model of the neuron: the running
  // sum, the five settings and the clamp / activation stages.
  class dot_scoreboard;
    bit        bias_en;
    act_mode_t mode;
    longint    slope;
    longint    clip_lo;
    longint    clip_hi;
    longint    run_sum;
    bit        sat_hit;
    result_t   expected_outputs[$];
    int        mismatches;
    int        outputs_checked;

    function new();
      bias_en = 1'b0;
      mode    = ACT_NONE;
      slope   = 0;
      clip_lo = 0;
      clip_hi = 0;
      run_sum = 0;
      mismatches = 0;
      outputs_checked = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_BIAS_ENABLE: bias_en = data[0];
        REG_ACT_MODE:    mode    = act_mode_t'(data[1:0]);
        REG_LEAKY_SLOPE: slope   = longint'($signed(data[SLOPE_WIDTH-1:0]));
        REG_CLIP_MIN:    clip_lo = longint'($signed(data[RES_WIDTH-1:0]));
        REG_CLIP_MAX:    clip_hi = longint'($signed(data[RES_WIDTH-1:0]));
        default: ;
      endcase
    endfunction

    function longint clamp_res(longint v);
      if (v > RES_HI) begin
        sat_hit = 1'b1;
        return RES_HI;
      end
      if (v < RES_LO) begin
        sat_hit = 1'b1;
        return RES_LO;
      end
      return v;
    endfunction

    function int pending();
      return expected_outputs.size();
    endfunction

    // Fold one accepted word into the sum; queue a result on a last word.
    function void note_word(item_t it);
      longint  prod;
      longint  x;
      result_t want;
      prod = longint'($signed(it.act_value)) * longint'($signed(it.weight_value));
      if (it.first_element)
        run_sum = bias_en ? longint'($signed(it.bias_value)) : 0;
      run_sum = run_sum + prod;
      if (run_sum > ACC_TOP)
        run_sum = ACC_TOP;
      else if (run_sum < ACC_BOTTOM)
        run_sum = ACC_BOTTOM;
      if (!it.last_element)
        return;
      sat_hit = 1'b0;
      x = clamp_res(run_sum);
      run_sum = 0;
      case (mode)
        ACT_RELU: begin
          if (x < 0)
            x = 0;
        end
        ACT_LEAKY: begin
          // arithmetic shift of a signed product floors toward minus infinity
          if (x <= 0)
            x = clamp_res((x * slope) >>> SLOPE_FRAC);
        end
        ACT_CLIP: begin
          if (x < clip_lo)
            x = clip_lo;
          if (x > clip_hi)
            x = clip_hi;
        end
        default: ;
      endcase
      want.result_value = x[RES_WIDTH-1:0];
      want.saturated    = sat_hit;
      expected_outputs.push_back(want);
    endfunction

    function void check_result(result_t got);
      result_t want;
      outputs_checked++;
      if (expected_outputs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: value %h sat %b",
                   got.result_value, got.saturated);
        return;
      end
      want = expected_outputs.pop_front();
      if (got.result_value !== want.result_value || got.saturated !== want.saturated) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch on result %0d: expected value %h sat %b, got value %h sat %b",
                   outputs_checked, want.result_value, want.saturated,
                   got.result_value, got.saturated);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  push;
  logic                  full;
  item_t                 item;
  logic                  empty;
  logic                  pop;
  result_t               result;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  dot_scoreboard sb;
  bit            no_idle;
  int            words_sent;
  longint        cycles;

  dot_product_bias_activation #(
    .ACC_WIDTH(ACC_W)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Roughly one cycle in five is an idle cycle, except during the
  // no-idle stretch.
  function automatic bit idle_now();
    return !no_idle && ($urandom_range(0, 99) < IDLE_PCT);
  endfunction

  function automatic item_t make_word(bit f, bit l, logic [DATA_WIDTH-1:0] a,
                                      logic [DATA_WIDTH-1:0] w, logic [RES_WIDTH-1:0] b);
    item_t it;
    it.first_element = f;
    it.last_element  = l;
    it.act_value     = a;
    it.weight_value  = w;
    it.bias_value    = b;
    return it;
  endfunction

  // Mix corner values into the element stream, otherwise full-range noise.
  function automatic logic [DATA_WIDTH-1:0] pick_elem();
    logic [DATA_WIDTH-1:0] r;
    r = DATA_WIDTH'($urandom);
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return '0;
      3: return {{8{r[15]}}, r[7:0]};
      default: return r;
    endcase
  endfunction

  function automatic logic [RES_WIDTH-1:0] pick_bound();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 5))
      0: return RES_MAX;
      1: return RES_MIN;
      2: return '0;
      3, 4: return {{4{r[27]}}, r[27:0]};
      default: return r;
    endcase
  endfunction

  function automatic logic [SLOPE_WIDTH-1:0] pick_slope();
    case ($urandom_range(0, 4))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return '0;
      3: return 16'h1000;
      default: return SLOPE_WIDTH'($urandom);
    endcase
  endfunction

  function automatic item_t rand_word(bit f, bit l);
    return make_word(f, l, pick_elem(), pick_elem(), pick_bound());
  endfunction

  // Offer one word and hold it until the block takes it. Push is left high
  // on return so back-to-back words need no extra assignment.
  task automatic send_word(item_t it);
    while (idle_now()) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    item <= it;
    @(posedge clk);
    while (full)
      @(posedge clk);
    sb.note_word(it);
    words_sent++;
  endtask

  // Drain all expected results, then give words that produce no result
  // time to clear the pipe.
  task automatic settle();
    push <= 1'b0;
    while (sb.pending() != 0)
      @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_reg(idx, data);
    @(posedge clk);
  endtask

  // Block must be idle here; write all five registers.
  task automatic set_config(bit be, act_mode_t m, logic [SLOPE_WIDTH-1:0] sl,
                            logic [RES_WIDTH-1:0] lo, logic [RES_WIDTH-1:0] hi);
    settle();
    write_reg(REG_BIAS_ENABLE, {{(CFG_DATA_W-1){1'b0}}, be});
    write_reg(REG_ACT_MODE, {{(CFG_DATA_W-2){1'b0}}, m});
    write_reg(REG_LEAKY_SLOPE, {{(CFG_DATA_W-SLOPE_WIDTH){sl[SLOPE_WIDTH-1]}}, sl});
    write_reg(REG_CLIP_MIN, lo);
    write_reg(REG_CLIP_MAX, hi);
  endtask

  task automatic run_directed();
    // reset settings: no bias, no activation
    send_word(make_word(1'b1, 1'b1, 16'h7FFF, 16'h7FFF, RES_MAX));
    send_word(make_word(1'b1, 1'b1, 16'h8000, 16'h8000, RES_MIN));
    send_word(make_word(1'b1, 1'b1, 16'h8000, 16'h7FFF, 32'h0));
    send_word(make_word(1'b1, 1'b1, 16'h0, 16'h0, 32'hFFFF_FFFF));
    // run with no first mark starts from the cleared sum
    send_word(make_word(1'b0, 1'b0, 16'hFFFF, 16'h0001, 32'h1234_5678));
    send_word(make_word(1'b0, 1'b1, 16'h0001, 16'h0001, 32'h0));
    send_word(make_word(1'b1, 1'b0, 16'h7FFF, 16'h8000, 32'h0));
    send_word(make_word(1'b0, 1'b1, 16'h1000, 16'h1000, 32'h0));

    // bias on: clamp to 32 bits on both sides
    set_config(1'b1, ACT_NONE, 16'h0, 32'h0, 32'h0);
    send_word(make_word(1'b1, 1'b1, 16'h8000, 16'h8000, RES_MAX));
    send_word(make_word(1'b1, 1'b1, 16'h8000, 16'h7FFF, RES_MIN));
    send_word(make_word(1'b1, 1'b1, 16'h0, 16'h0, 32'hFFFF_FFFF));

    set_config(1'b1, ACT_RELU, 16'h0, 32'h0, 32'h0);
    send_word(make_word(1'b1, 1'b1, 16'h0, 16'h0, -32'sd100));
    send_word(make_word(1'b1, 1'b1, 16'h4000, 16'h4000, RES_MAX));
    send_word(make_word(1'b1, 1'b1, 16'h0, 16'h0, 32'd12345));

    // leaky with the steepest negative slope overflows the result
    set_config(1'b1, ACT_LEAKY, 16'h8000, 32'h0, 32'h0);
    send_word(make_word(1'b1, 1'b1, 16'h0, 16'h0, RES_MIN));
    send_word(make_word(1'b1, 1'b1, 16'h0, 16'h0, 32'h0));
    send_word(make_word(1'b1, 1'b1, 16'h0, 16'h0, 32'd5000));
    // rounding toward minus infinity on a tiny negative value
    set_config(1'b1, ACT_LEAKY, 16'h0001, 32'h0, 32'h0);
    send_word(make_word(1'b1, 1'b1, 16'h0, 16'h0, 32'hFFFF_FFFF));
    set_config(1'b1, ACT_LEAKY, 16'h7FFF, 32'h0, 32'h0);
    send_word(make_word(1'b1, 1'b1, 16'h8000, 16'h7FFF, RES_MIN));

    set_config(1'b1, ACT_CLIP, 16'h0, -32'sd1000, 32'sd1000);
    send_word(make_word(1'b1, 1'b1, 16'h0, 16'h0, 32'd5000));
    send_word(make_word(1'b1, 1'b1, 16'h0, 16'h0, -32'sd5000));
    send_word(make_word(1'b1, 1'b1, 16'h0, 16'h0, 32'd7));
    // inverted bounds: result always lands on the upper bound
    set_config(1'b1, ACT_CLIP, 16'h0, RES_MAX, RES_MIN);
    send_word(make_word(1'b1, 1'b1, 16'h0, 16'h0, 32'h0));
  endtask

  // Push the sum far past the 32-bit range, then walk part of the way back
  // so that the clamp still shows up in the result.
  task automatic long_sum(logic [DATA_WIDTH-1:0] a1, logic [DATA_WIDTH-1:0] w1, int n1,
                          logic [DATA_WIDTH-1:0] a2, logic [DATA_WIDTH-1:0] w2, int n2);
    for (int i = 0; i < n1; i++)
      send_word(make_word(i == 0, 1'b0, a1, w1, 32'h0));
    for (int i = 0; i < n2; i++)
      send_word(make_word(1'b0, i == n2 - 1, a2, w2, 32'h0));
  endtask

  // Mostly well-formed runs with random content, some stray marks.
  task automatic run_random_phase(int n);
    int sent;
    int len;
    bit run_open;
    bit f;
    bit l;
    sent = 0;
    run_open = 1'b0;
    while (sent < n) begin
      if ($urandom_range(0, 99) < 85) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
        for (int k = 0; k < len; k++)
          send_word(rand_word(k == 0, k == len - 1));
        sent += len;
        run_open = 1'b0;
      end else begin
        f = 1'($urandom_range(0, 1));
        l = 1'($urandom_range(0, 1));
        send_word(rand_word(f, l));
        sent++;
        run_open = !l;
      end
    end
    // close any dangling run so no sum spans a settings change
    if (run_open)
      send_word(rand_word(1'b0, 1'b1));
  endtask

  // Result side: check on every pop handshake, stall at random.
  initial begin
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty)
        sb.check_result(result);
      pop <= !idle_now();
    end
  end

  // Watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d results still expected", cycles, sb.pending());
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  initial begin
    act_mode_t mode_cycle[4];
    mode_cycle = '{ACT_NONE, ACT_RELU, ACT_LEAKY, ACT_CLIP};
    sb = new();
    no_idle = 1'b0;
    words_sent = 0;
    rst       <= 1'b1;
    push      <= 1'b0;
    item      <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_BIAS_ENABLE;
    cfg_data  <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();

    // Long sums double as the stretch with no idling on either side.
    set_config(1'b0, ACT_NONE, 16'h0, 32'h0, 32'h0);
    no_idle = 1'b1;
    long_sum(16'h8000, 16'h8000, 24, 16'h8000, 16'h7FFF, 20);
    long_sum(16'h8000, 16'h7FFF, 26, 16'h8000, 16'h8000, 16);
    no_idle = 1'b0;

    for (int p = 0; p < 10; p++) begin
      set_config(1'($urandom_range(0, 1)),
                 (p < 8) ? mode_cycle[2'(p % 4)] : mode_cycle[2'($urandom_range(0, 3))],
                 pick_slope(), pick_bound(), pick_bound());
      run_random_phase(92);
    end

    // drain, then watch for stray results
    settle();
    repeat (20) @(posedge clk);
    if (sb.pending() != 0)
      $display("%0d expected results never arrived", sb.pending());
    $display("pushed %0d words and checked %0d results with %0d mismatches",
             words_sent, sb.outputs_checked, sb.mismatches);
    $display("covered all activation modes, bias on and off, sums clamped to 32 bits");
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
